// File: design/toy_risc_execute_unit_defines.svh
// assertion macros for the toy risc execute unit checker
// needs clk_i and rst_ni in the scope of each use
`ifndef TOY_RISC_EXECUTE_UNIT_DEFINES_SVH
`define TOY_RISC_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tre_pkg.sv
// shared types and constants of the toy risc execute unit
// used by the front, queue and back modules and the top level
package tre_pkg;

  localparam int REG_W         = 5;
  localparam int DATA_W        = 32;
  localparam int TGT_W         = 10;
  localparam int FUNC_W        = 4;
  localparam int PROGRAM_DEPTH = 1024;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_W          = 64;
  localparam int OUT_W         = 56;

  // instruction codes as they arrive on the input stream
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD  = 4'd0,
    FUNC_ADDI = 4'd1,
    FUNC_SUB  = 4'd2,
    FUNC_MULT = 4'd3,
    FUNC_DIV  = 4'd4,
    FUNC_B    = 4'd5,
    FUNC_BEQ  = 4'd6,
    FUNC_BNQ  = 4'd7,
    FUNC_LOAD = 4'd8
  } func_e;

  // operation class handed from the front to the back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_ADDI,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BR,
    OP_BEQ,
    OP_BNE,
    OP_LOAD
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src_a_reg;
    logic [REG_W-1:0]  src_b_reg;
    logic [DATA_W-1:0] immediate;
    logic [TGT_W-1:0]  branch_target;
  } instr_t;

  typedef struct packed {
    logic              divide_by_zero;
    logic [TGT_W-1:0]  next_index;
    logic              branch_taken;
    logic [DATA_W-1:0] write_value;
    logic [REG_W-1:0]  write_reg;
    logic              wrote;
  } result_t;

endpackage

// File: design/tre_front.sv
// front end: classifies an incoming instruction and hands it to the queue
// depends on tre_pkg
module tre_front (
  input  logic [tre_pkg::FUNC_W-1:0] func_i,
  input  logic [tre_pkg::REG_W-1:0]  dest_reg_i,
  input  logic [tre_pkg::REG_W-1:0]  src_a_reg_i,
  input  logic [tre_pkg::REG_W-1:0]  src_b_reg_i,
  input  logic [tre_pkg::DATA_W-1:0] immediate_i,
  input  logic [tre_pkg::TGT_W-1:0]  branch_target_i,
  output tre_pkg::instr_t            instr_o
);
  import tre_pkg::*;

  op_e op;

  always_comb begin
    unique case (func_i)
      FUNC_ADD:  op = OP_ADD;
      FUNC_ADDI: op = OP_ADDI;
      FUNC_SUB:  op = OP_SUB;
      FUNC_MULT: op = OP_MUL;
      FUNC_DIV:  op = OP_DIV;
      FUNC_B:    op = OP_BR;
      FUNC_BEQ:  op = OP_BEQ;
      FUNC_BNQ:  op = OP_BNE;
      FUNC_LOAD: op = OP_LOAD;
      default:   op = OP_NONE;
    endcase
  end

  always_comb begin
    instr_o.op            = op;
    instr_o.dest_reg      = dest_reg_i;
    instr_o.src_a_reg     = src_a_reg_i;
    instr_o.src_b_reg     = src_b_reg_i;
    instr_o.immediate     = immediate_i;
    // targets wrap at the program depth
    instr_o.branch_target = TGT_W'(32'(branch_target_i) % PROGRAM_DEPTH);
  end

endmodule

// File: design/tre_queue.sv
// short instruction queue between the front and the back
// depends on tre_pkg
module tre_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  tre_pkg::instr_t push_data_i,
  output logic            valid_o,
  input  logic            pop_i,
  output tre_pkg::instr_t pop_data_o
);
  import tre_pkg::*;

  instr_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign ready_o    = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/tre_back.sv
// back end: register file, alu, iterative divider and result register
// depends on tre_pkg
module tre_back #(
  parameter int NUM_REGS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  tre_pkg::instr_t            q_data_i,
  output logic                       q_pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output tre_pkg::result_t           m_result_o
);
  import tre_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int EXT_W = (IDX_W > REG_W) ? IDX_W : REG_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_DWB  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  instr_t            instr_q, instr_d;

  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [DATA_W-1:0] rdata_a_q, rdata_b_q;
  logic              rvld_a_q, rvld_b_q;

  logic [EXT_W-1:0]  a_ext, b_ext, d_ext;
  logic [IDX_W-1:0]  idx_a, idx_b, idx_d;
  logic              ok_a, ok_b, ok_d;
  logic [DATA_W-1:0] op_a, op_b;

  // divider state
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [REG_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W:0]   rem_sh, diff;
  logic              ge;

  result_t           res;
  result_t           out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;
  logic              res_ready;
  logic              fin;
  logic              wr_en;

  assign a_ext = EXT_W'(instr_q.src_a_reg);
  assign b_ext = EXT_W'(instr_q.src_b_reg);
  assign d_ext = EXT_W'(instr_q.dest_reg);
  assign idx_a = a_ext[IDX_W-1:0];
  assign idx_b = b_ext[IDX_W-1:0];
  assign idx_d = d_ext[IDX_W-1:0];
  assign ok_a  = 32'(instr_q.src_a_reg) < 32'(NUM_REGS);
  assign ok_b  = 32'(instr_q.src_b_reg) < 32'(NUM_REGS);
  assign ok_d  = 32'(instr_q.dest_reg) < 32'(NUM_REGS);

  // never-written and out-of-range registers read as zero
  assign op_a = (ok_a && rvld_a_q) ? rdata_a_q : '0;
  assign op_b = (ok_b && rvld_b_q) ? rdata_b_q : '0;

  // one restoring step of the unsigned magnitude divide
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[DATA_W];

  assign out_free = !out_vld_q || m_ready_i;

  always_comb begin
    logic [DATA_W-1:0] val;
    logic              wr;
    logic              taken;
    logic              dz;
    val       = '0;
    wr        = 1'b0;
    taken     = 1'b0;
    dz        = 1'b0;
    res_ready = 1'b1;
    if (state_q == S_DWB) begin
      val = neg_q ? (~quo_q + 1'b1) : quo_q;
      wr  = 1'b1;
    end else begin
      unique case (instr_q.op)
        OP_ADD:  begin val = op_a + op_b;              wr = 1'b1; end
        OP_ADDI: begin val = op_a + instr_q.immediate; wr = 1'b1; end
        OP_SUB:  begin val = op_a - op_b;              wr = 1'b1; end
        OP_MUL:  begin val = DATA_W'(op_a * op_b);     wr = 1'b1; end
        OP_DIV: begin
          wr = 1'b1;
          if (op_b == '0) begin
            dz = 1'b1;
          end else begin
            res_ready = 1'b0;
          end
        end
        OP_BR:   taken = 1'b1;
        OP_BEQ:  taken = op_a == op_b;
        OP_BNE:  taken = op_a != op_b;
        OP_LOAD: begin val = instr_q.immediate; wr = 1'b1; end
        default: ;
      endcase
    end
    res.wrote          = wr && ok_d;
    res.write_reg      = wr ? instr_q.dest_reg : '0;
    res.write_value    = wr ? val : '0;
    res.branch_taken   = taken;
    res.next_index     = taken ? instr_q.branch_target : '0;
    res.divide_by_zero = dz;
  end

  always_comb begin
    state_d   = state_q;
    instr_d   = instr_q;
    q_pop_o   = 1'b0;
    fin       = 1'b0;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          instr_d = q_data_i;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (!res_ready) begin
          rem_d   = '0;
          quo_d   = op_a[DATA_W-1] ? (~op_a + 1'b1) : op_a;
          dvs_d   = op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b;
          neg_d   = op_a[DATA_W-1] ^ op_b[DATA_W-1];
          cnt_d   = REG_W'(DATA_W - 1);
          state_d = S_DIV;
        end else if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        rem_d = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DWB;
        end
      end
      S_DWB: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign wr_en = fin && res.wrote;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (fin) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (wr_en) begin
        vld_q[idx_d] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q <= instr_d;
    out_q   <= out_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      regs[idx_d] <= res.write_value;
    end
    rdata_a_q <= regs[idx_a];
    rdata_b_q <= regs[idx_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      rvld_a_q <= vld_q[idx_a];
      rvld_b_q <= vld_q[idx_b];
    end
  end

  assign m_valid_o  = out_vld_q;
  assign m_result_o = out_q;

endmodule

// File: design/toy_risc_execute_unit.sv
// channel   dir  width  fields (lsb first)
// s_axis    in   64     func, dest_reg, src_a_reg, src_b_reg, immediate, branch_target
// m_axis    out  56     wrote, write_reg, write_value, branch_taken, next_index,
//                       divide_by_zero
//
// an instruction passes read and exec states, div also divide states (one quotient
// bit a cycle in the iterative divider); the back handles one instruction at a time
// the front and a two-entry queue keep taking requests while the back is busy
// a finished result sits in the output register, so a stall on m_axis only
// holds the back once a second result is ready; reset clears register valid bits
// top level: decoupled front, queue and back of the toy risc execute unit
// depends on tre_pkg, tre_front, tre_queue and tre_back
module toy_risc_execute_unit #(
  parameter int NUM_REGS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // func, dest_reg, src_a_reg, src_b_reg, immediate, branch_target, zero pad
  input  logic [tre_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // wrote, write_reg, write_value, branch_taken, next_index, divide_by_zero, zero pad
  output logic [tre_pkg::OUT_W-1:0] m_axis_tdata
);
  import tre_pkg::*;

  instr_t  front_instr;
  instr_t  q_data;
  logic    q_valid;
  logic    q_pop;
  result_t result;

  tre_front u_front (
    .func_i          (s_axis_tdata[3:0]),
    .dest_reg_i      (s_axis_tdata[8:4]),
    .src_a_reg_i     (s_axis_tdata[13:9]),
    .src_b_reg_i     (s_axis_tdata[18:14]),
    .immediate_i     (s_axis_tdata[50:19]),
    .branch_target_i (s_axis_tdata[60:51]),
    .instr_o         (front_instr)
  );

  tre_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .push_data_i (front_instr),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  tre_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = {6'b0, result};

endmodule

// File: design/tre_checker.sv
// port-level checker for the toy risc execute unit, bound to the top level
// depends on tre_pkg and toy_risc_execute_unit_defines.svh
`include "toy_risc_execute_unit_defines.svh"

module tre_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_i,
  input logic                      m_axis_tvalid_i,
  input logic                      m_axis_tready_i,
  input logic [tre_pkg::OUT_W-1:0] m_axis_tdata_i
);
  import tre_pkg::*;

  logic [3:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_i;
  assign out_acc = m_axis_tvalid_i && m_axis_tready_i;
  assign pend_d  = pend_q + 4'(in_acc) - 4'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a result only ever answers an earlier request
  `TRE_ASSERT_NOW(a_no_orphan, m_axis_tvalid_i, pend_q != 4'd0, "result without request")
  `TRE_ASSERT_NOW(a_nt_zero, m_axis_tvalid_i && !m_axis_tdata_i[38],
    m_axis_tdata_i[48:39] == 10'd0, "next_index set on untaken branch")
  `TRE_ASSERT_NOW(a_dz_clean, m_axis_tvalid_i && m_axis_tdata_i[49],
    (m_axis_tdata_i[37:6] == 32'd0) && !m_axis_tdata_i[38], "bad divide by zero result")
  `TRE_ASSERT_NEXT(a_hold_vld, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i,
    "result dropped while stalled")
  `TRE_ASSERT_NEXT(a_hold_data, m_axis_tvalid_i && !m_axis_tready_i,
    $stable(m_axis_tdata_i), "result changed while stalled")

endmodule

bind toy_risc_execute_unit tre_checker u_tre_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);
